### src/hcb_pkg.sv
// ============================================================================
// hcb_pkg: shared types and constants for the Huffman code builder
// Holds the list sizes, field widths, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ============================================================================
`default_nettype none
package hcb_pkg;

	localparam int LEAVES = 32;
	localparam int ID_W   = 6;   // node number, 0 .. 2*LEAVES-2
	localparam int POS_W  = 5;   // position in the live list
	localparam int CNT_W  = 6;   // counts 0 .. LEAVES
	localparam int WGT_W  = 40;  // merged weights grow past 32 bits
	localparam int CODE_W = 63;
	localparam int LINK_W = ID_W + 1;  // parent number and right-child flag

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_START = 7'b0000010,
		ST_SCAN  = 7'b0000100,
		ST_WRA   = 7'b0001000,
		ST_MERGE = 7'b0010000,
		ST_CHK   = 7'b0100000,
		ST_STEP  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic load;       // store the accepted weight beat
		logic scan_step;  // examine one live list entry
		logic wr_a;       // link the left child to its parent
		logic merge;      // link the right child, compact and append
		logic walk_step;  // climb one level toward the root
		logic out_load;   // put the current leaf's code in the output register
		logic leaf_next;  // move on to the next leaf
		logic block_clear;
	} cmd_t;

	typedef struct packed {
		logic live_gt1;
		logic scan_done;
		logic at_root;
		logic last_leaf;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

### src/hcb_ram.sv
// ============================================================================
// hcb_ram: generic memory with one write port and one registered read port
// ============================================================================
`default_nettype none
module hcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### src/hcb_datapath.sv
// ============================================================================
// hcb_datapath: live list, minimum scanner, parent links and code walker
// Executes the controller's commands and reports status back.
// ============================================================================
`default_nettype none
module hcb_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire hcb_pkg::cmd_t             cmd,
	output hcb_pkg::status_t               sts,
	input  wire logic [31:0]               weight,
	input  wire logic                      last,
	output logic                           res_valid,
	input  wire logic                      res_stall,
	output logic [hcb_pkg::ID_W-1:0]       symbol,
	output logic [hcb_pkg::ID_W-1:0]       code_length,
	output logic [hcb_pkg::CODE_W-1:0]     code_bits,
	output logic                           overflow,
	output logic                           final_res
);
	import hcb_pkg::*;

	logic [WGT_W-1:0] list_w_q  [LEAVES];
	logic [ID_W-1:0]  list_id_q [LEAVES];
	logic [CNT_W-1:0] lc_q, n_q, live_q;
	logic             ovf_q;
	logic [ID_W-1:0]  next_q;
	logic [POS_W-1:0] p_q;
	logic             m1_v_q, m2_v_q;
	logic [WGT_W-1:0] m1_w_q, m2_w_q;
	logic [POS_W-1:0] m1_p_q, m2_p_q;
	logic [ID_W-1:0]  m1_id_q, m2_id_q;
	logic [ID_W-1:0]  leaf_q, node_q, k_q;
	logic [CODE_W-1:0] code_q;
	logic [ID_W-1:0]  root;
	logic [WGT_W-1:0] cur_w;
	logic [POS_W-1:0] lo, hi;
	logic             ram_we;
	logic [ID_W-1:0]  ram_waddr;
	logic [LINK_W-1:0] ram_wdata, ram_rdata;

	assign root  = ID_W'({n_q, 1'b0} - 7'd2);
	assign cur_w = list_w_q[p_q];
	assign lo    = (m1_p_q < m2_p_q) ? m1_p_q : m2_p_q;
	assign hi    = (m1_p_q < m2_p_q) ? m2_p_q : m1_p_q;

	assign sts.live_gt1  = live_q > CNT_W'(1);
	assign sts.scan_done = {1'b0, p_q} == live_q - CNT_W'(1);
	assign sts.at_root   = node_q == root;
	assign sts.last_leaf = {1'b0, leaf_q} == {1'b0, n_q} - 7'd1;
	assign sts.out_free  = !res_valid || !res_stall;

	assign ram_we    = cmd.wr_a || cmd.merge;
	assign ram_waddr = cmd.merge ? m2_id_q : m1_id_q;
	assign ram_wdata = {next_q, cmd.merge};

	hcb_ram #(.WIDTH(LINK_W), .DEPTH(64)) u_links (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(node_q), .rdata(ram_rdata)
	);

	// Control counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q      <= '0;
			ovf_q     <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (lc_q < CNT_W'(LEAVES)) begin
					lc_q <= lc_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.block_clear) begin
				lc_q  <= '0;
				ovf_q <= 1'b0;
			end
			if (cmd.out_load) begin
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	// Build and walk registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (lc_q < CNT_W'(LEAVES)) begin
				list_w_q[lc_q[POS_W-1:0]]  <= WGT_W'(weight);
				list_id_q[lc_q[POS_W-1:0]] <= lc_q;
			end
			if (last) begin
				n_q    <= (lc_q < CNT_W'(LEAVES)) ? lc_q + CNT_W'(1) : lc_q;
				live_q <= (lc_q < CNT_W'(LEAVES)) ? lc_q + CNT_W'(1) : lc_q;
				next_q <= (lc_q < CNT_W'(LEAVES)) ? lc_q + CNT_W'(1) : lc_q;
			end
			p_q    <= '0;
			m1_v_q <= 1'b0;
			m2_v_q <= 1'b0;
			leaf_q <= '0;
			node_q <= '0;
			k_q    <= '0;
			code_q <= '0;
		end
		if (cmd.scan_step) begin
			if (!m1_v_q || cur_w < m1_w_q) begin
				m1_v_q  <= 1'b1;
				m1_w_q  <= cur_w;
				m1_p_q  <= p_q;
				m1_id_q <= list_id_q[p_q];
				m2_v_q  <= m1_v_q;
				m2_w_q  <= m1_w_q;
				m2_p_q  <= m1_p_q;
				m2_id_q <= m1_id_q;
			end else if (!m2_v_q || cur_w < m2_w_q) begin
				m2_v_q  <= 1'b1;
				m2_w_q  <= cur_w;
				m2_p_q  <= p_q;
				m2_id_q <= list_id_q[p_q];
			end
			p_q <= p_q + POS_W'(1);
		end
		if (cmd.merge) begin
			for (int k = 0; k < LEAVES; k++) begin
				if (k >= int'(lo) && k < int'(hi) - 1 && k + 1 < LEAVES) begin
					list_w_q[k]  <= list_w_q[k+1];
					list_id_q[k] <= list_id_q[k+1];
				end else if (k >= int'(hi) - 1 && k >= int'(lo) && k + 2 < LEAVES) begin
					list_w_q[k]  <= list_w_q[k+2];
					list_id_q[k] <= list_id_q[k+2];
				end
			end
			list_w_q[POS_W'(live_q - CNT_W'(2))]  <= m1_w_q + m2_w_q;
			list_id_q[POS_W'(live_q - CNT_W'(2))] <= next_q;
			live_q <= live_q - CNT_W'(1);
			next_q <= next_q + ID_W'(1);
			p_q    <= '0;
			m1_v_q <= 1'b0;
			m2_v_q <= 1'b0;
		end
		if (cmd.walk_step) begin
			if (ram_rdata[0]) begin
				code_q <= code_q | (CODE_W'(1) << k_q);
			end
			node_q <= ram_rdata[LINK_W-1:1];
			k_q    <= k_q + ID_W'(1);
		end
		if (cmd.leaf_next) begin
			leaf_q <= leaf_q + ID_W'(1);
			node_q <= leaf_q + ID_W'(1);
			k_q    <= '0;
			code_q <= '0;
		end
		if (cmd.out_load) begin
			symbol      <= leaf_q;
			code_length <= k_q;
			code_bits   <= code_q;
			overflow    <= ovf_q;
			final_res   <= sts.last_leaf;
		end
	end

	a_lc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lc_q <= CNT_W'(LEAVES)) else $error("leaf count beyond list size");
	a_merge_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge |=> live_q == $past(live_q) - CNT_W'(1))
		else $error("merge did not shrink live list");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free) else $error("output overwritten");
endmodule
`default_nettype wire

### src/hcb_controller.sv
// ============================================================================
// hcb_controller: sequencer for load, merge rounds and code emission
// ============================================================================
`default_nettype none
module hcb_controller (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid,
	input  wire logic             last,
	output logic                  stall,
	input  wire hcb_pkg::status_t sts,
	output hcb_pkg::cmd_t         cmd
);
	import hcb_pkg::*;

	state_t state_q, state_d;

	assign stall = state_q != ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (valid) begin
					cmd.load = 1'b1;
					if (last) state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = sts.live_gt1 ? ST_SCAN : ST_CHK;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = ST_WRA;
			end
			ST_WRA: begin
				cmd.wr_a = 1'b1;
				state_d  = ST_MERGE;
			end
			ST_MERGE: begin
				cmd.merge = 1'b1;
				state_d   = ST_START;
			end
			ST_CHK: begin
				if (!sts.at_root) begin
					state_d = ST_STEP;
				end else if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.last_leaf) begin
						cmd.block_clear = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.leaf_next = 1'b1;
					end
				end
			end
			ST_STEP: begin
				cmd.walk_step = 1'b1;
				state_d = ST_CHK;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !stall) else $error("load outside idle");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.scan_step, cmd.wr_a, cmd.merge, cmd.walk_step}))
		else $error("conflicting commands");
	a_wra_merge: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_a |=> cmd.merge) else $error("left link without merge");
endmodule
`default_nettype wire

### src/huffman_code_builder_unit.sv
// ============================================================================
// huffman_code_builder_unit: Huffman code construction from symbol weights
// Top level joining the controller and the datapath.
// ============================================================================
// Weights arrive one beat per cycle and are numbered in arrival order; up to
// 32 are kept and any beyond that are dropped and flag overflow on every code
// of the block. The beat marked last starts the build, and the input stalls
// until the last code of the block has been loaded into the output register.
// Each merge round enters a start state, scans the live list one entry per
// cycle, links the left child, then links the right child and compacts the
// list. Codes then come out in symbol order, one per leaf, as the walker
// climbs the parent links held in a small memory with a registered read. A
// code is root edge first, right-aligned, with left as 0 and right as 1; a
// single symbol gets a code of length zero.
`default_nettype none
module huffman_code_builder_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      valid,
	output logic                           stall,
	input  wire logic [31:0]               weight,
	input  wire logic                      last,
	output logic                           res_valid,
	input  wire logic                      res_stall,
	output logic [hcb_pkg::ID_W-1:0]       symbol,
	output logic [hcb_pkg::ID_W-1:0]       code_length,
	output logic [hcb_pkg::CODE_W-1:0]     code_bits,
	output logic                           overflow,
	output logic                           final_res
);
	import hcb_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// The controller sequences loading, merge rounds and the code walk.
	hcb_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .valid(valid), .last(last),
		.stall(stall), .sts(sts), .cmd(cmd)
	);

	// The datapath holds the live list, parent links and output register.
	hcb_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.weight(weight), .last(last),
		.res_valid(res_valid), .res_stall(res_stall),
		.symbol(symbol), .code_length(code_length), .code_bits(code_bits),
		.overflow(overflow), .final_res(final_res)
	);
endmodule
`default_nettype wire
